### rtl/cpts_pkg.sv
// Shared types, constants and helpers of the counter/priority task scheduler.
`default_nettype none

package cpts_pkg;

   // Default number of task slots.
   localparam int NUM_TASKS_DEF = 64;

   // Operation codes carried by req_op; codes five to seven do nothing.
   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_YIELD = 3'd1,
      OP_WRITE = 3'd2,
      OP_RAISE = 3'd3,
      OP_LOWER = 3'd4
   } op_type;

   // Saturation limits of the time counter and the preemption count.
   localparam logic signed [10:0] CNT_MIN = 11'b100_0000_0000;
   localparam logic signed [10:0] CNT_MAX = 11'b011_1111_1111;
   localparam logic [3:0]         PRE_MAX = 4'hF;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_READ,
      ST_RESP
   } state_type;

   // One task slot as it is kept in the slot memory.
   typedef struct packed {
      logic              present;
      logic              runnable;
      logic [7:0]        prio;
      logic signed [10:0] counter;
      logic [3:0]        preempt;
   } slot_entry_type;

   // Contents of a slot that has not been written since reset.
   function automatic slot_entry_type reset_entry(input logic is_slot0);
      slot_entry_type e;
      e.present  = is_slot0;
      e.runnable = is_slot0;
      e.prio     = 8'd1;
      e.counter  = '0;
      e.preempt  = '0;
      return e;
   endfunction

endpackage : cpts_pkg

`default_nettype wire

### rtl/cpts_slot_mem.sv
// Slot memory of the scheduler: one write port, one registered read port, reset by valid bits.
`default_nettype none

module cpts_slot_mem #(
   parameter int  NUM_TASKS = cpts_pkg::NUM_TASKS_DEF,
   localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [IDX_W-1:0]         rd_addr,
   output      cpts_pkg::slot_entry_type rd_data,
   input  wire logic                     wr_en,
   input  wire logic [IDX_W-1:0]         wr_addr,
   input  wire cpts_pkg::slot_entry_type wr_data
);
   import cpts_pkg::*;

   slot_entry_type             slot_mem_ff [NUM_TASKS];
   logic [NUM_TASKS-1:0]       vld_ff;
   slot_entry_type             rd_data_ff;
   logic                       rd_vld_ff;
   logic                       rd_zero_ff;

   // Memory array: write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem_ff[rd_addr];
      rd_zero_ff <= (rd_addr == '0);
   end

   // Valid bits: an entry never written since reset reads as its reset contents.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : reset_entry(rd_zero_ff);

endmodule : cpts_slot_mem

`default_nettype wire

### rtl/counter_priority_task_scheduler_top.sv
// Top level of the counter/priority task scheduler: sequencer, selection scan and result register.
//
//   Channel   Ports                               Transfer
//   request   start, busy, req_*                  start high while busy is low
//   response  rsp_strobe, rsp_*                   rsp_strobe high for one cycle
//
// An item runs through modify, read and response; a reschedule adds a scan
// of the slot memory, and a second scan when that pass recharges. The single
// read port of the slot memory sets the scan length: each scan reads one slot
// a cycle. Reset is synchronous and clears the sequencer and the slot valid
// bits at once, so no clearing pass is needed. The receiver cannot stall; the
// result register frees busy in the cycle the result is shown.
`default_nettype none

module counter_priority_task_scheduler_top #(
   parameter int NUM_TASKS = cpts_pkg::NUM_TASKS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [2:0]         req_op,
   input  wire logic [5:0]         req_slot,
   input  wire logic               req_present,
   input  wire logic               req_runnable,
   input  wire logic [7:0]         req_priority_req,
   input  wire logic signed [10:0] req_counter_value,
   output      logic               rsp_strobe,
   output      logic [5:0]         rsp_current_task,
   output      logic               rsp_switched,
   output      logic               rsp_rescheduled,
   output      logic               rsp_recharged,
   output      logic signed [10:0] rsp_current_counter,
   output      logic [3:0]         rsp_current_preempt
);
   import cpts_pkg::*;

   localparam int             IDX_W   = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam logic [IDX_W:0] NUM_CNT = (IDX_W+1)'(NUM_TASKS);
   localparam logic signed [11:0] SUM_MAX = 12'sd1023;
   localparam logic signed [11:0] SUM_MIN = -12'sd1024;

   state_type          state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic [5:0]         slot_ff, slot_in;
   logic               pres_ff, pres_in;
   logic               run_ff, run_in;
   logic [7:0]         prio_ff, prio_in;
   logic signed [10:0] cval_ff, cval_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic               resched_ff, resched_in;
   logic               recharge_ff, recharge_in;
   logic               switched_ff, switched_in;
   logic [IDX_W:0]     scan_cnt_ff, scan_cnt_in;
   logic               sample_ff, sample_in;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic signed [10:0] best_ff, best_in;
   logic [IDX_W-1:0]   pick_ff, pick_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [5:0]         rsp_task_ff, rsp_task_in;
   logic               rsp_sw_ff, rsp_sw_in;
   logic               rsp_rs_ff, rsp_rs_in;
   logic               rsp_rc_ff, rsp_rc_in;
   logic signed [10:0] rsp_cnt_ff, rsp_cnt_in;
   logic [3:0]         rsp_pre_ff, rsp_pre_in;

   logic [IDX_W-1:0]   rd_addr;
   slot_entry_type     rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   slot_entry_type     wr_data;

   logic signed [10:0] ent_cnt;
   logic signed [10:0] cnt_dec;
   logic signed [10:0] cnt_half;
   logic signed [11:0] rch_sum;
   logic signed [10:0] rch_cnt;
   logic signed [10:0] scan_cnt_val;
   logic               tick_resched;
   logic               slot_ok;
   logic [IDX_W-1:0]   slot_idx;

   cpts_slot_mem #(
      .NUM_TASKS (NUM_TASKS)
   ) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Arithmetic on the slot that was read last cycle.
   always_comb begin
      ent_cnt      = rd_data.counter;
      cnt_dec      = (ent_cnt == CNT_MIN) ? CNT_MIN : ent_cnt - 11'sd1;
      tick_resched = !((cnt_dec > 11'sd0) || (rd_data.preempt != '0));
      cnt_half     = ent_cnt >>> 1;
      rch_sum      = $signed({cnt_half[10], cnt_half}) + $signed({4'b0000, rd_data.prio});
      if (rch_sum > SUM_MAX) begin
         rch_cnt = CNT_MAX;
      end else if (rch_sum < SUM_MIN) begin
         rch_cnt = CNT_MIN;
      end else begin
         rch_cnt = rch_sum[10:0];
      end
      scan_cnt_val = recharge_ff ? rch_cnt : ent_cnt;
      slot_ok      = (int'(slot_ff) < NUM_TASKS);
      slot_idx     = IDX_W'(slot_ff);
   end

   // Sequencer: next state, memory accesses and result.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      pres_in       = pres_ff;
      run_in        = run_ff;
      prio_in       = prio_ff;
      cval_in       = cval_ff;
      cur_in        = cur_ff;
      resched_in    = resched_ff;
      recharge_in   = recharge_ff;
      switched_in   = switched_ff;
      scan_cnt_in   = scan_cnt_ff;
      sample_in     = 1'b0;
      best_in       = best_ff;
      pick_in       = pick_ff;
      rsp_strobe_in = 1'b0;
      rsp_task_in   = rsp_task_ff;
      rsp_sw_in     = rsp_sw_ff;
      rsp_rs_in     = rsp_rs_ff;
      rsp_rc_in     = rsp_rc_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_pre_in    = rsp_pre_ff;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = rd_data;

      case (state_ff)
         ST_IDLE: begin
            // Read the slot that the operation modifies.
            if (req_op == OP_WRITE) begin
               rd_addr = IDX_W'(req_slot);
            end
            if (start) begin
               op_in       = req_op;
               slot_in     = req_slot;
               pres_in     = req_present;
               run_in      = req_runnable;
               prio_in     = req_priority_req;
               cval_in     = req_counter_value;
               resched_in  = 1'b0;
               recharge_in = 1'b0;
               switched_in = 1'b0;
               state_in    = ST_MODIFY;
            end
         end

         ST_MODIFY: begin
            // Write back the modified slot; a reschedule starts a scan.
            state_in    = ST_READ;
            scan_cnt_in = '0;
            best_in     = -11'sd1;
            pick_in     = '0;
            case (op_ff)
               OP_TICK: begin
                  wr_en           = 1'b1;
                  wr_data.counter = tick_resched ? 11'sd0 : cnt_dec;
                  if (tick_resched) begin
                     resched_in = 1'b1;
                     state_in   = ST_SCAN;
                  end
               end
               OP_YIELD: begin
                  wr_en           = 1'b1;
                  wr_data.counter = 11'sd0;
                  resched_in      = 1'b1;
                  state_in        = ST_SCAN;
               end
               OP_WRITE: begin
                  wr_en            = slot_ok;
                  wr_addr          = slot_idx;
                  wr_data.present  = pres_ff;
                  wr_data.runnable = run_ff;
                  wr_data.prio     = (prio_ff == '0) ? 8'd1 : prio_ff;
                  wr_data.counter  = cval_ff;
               end
               OP_RAISE: begin
                  wr_en = 1'b1;
                  if (rd_data.preempt != PRE_MAX) begin
                     wr_data.preempt = rd_data.preempt + 4'd1;
                  end
               end
               OP_LOWER: begin
                  wr_en = 1'b1;
                  if (rd_data.preempt != '0) begin
                     wr_data.preempt = rd_data.preempt - 4'd1;
                  end
               end
               default: begin
                  wr_en = 1'b0;
               end
            endcase
         end

         ST_SCAN: begin
            // Issue one slot read per cycle.
            rd_addr = scan_cnt_ff[IDX_W-1:0];
            if (scan_cnt_ff != NUM_CNT) begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
               sample_in   = 1'b1;
            end
            // Evaluate the slot read last cycle; the recharge pass writes it back.
            if (sample_ff) begin
               if (recharge_ff && rd_data.present) begin
                  wr_en           = 1'b1;
                  wr_addr         = rd_idx_ff;
                  wr_data.counter = rch_cnt;
               end
               if (rd_data.present && rd_data.runnable && (scan_cnt_val > best_ff)) begin
                  best_in = scan_cnt_val;
                  pick_in = rd_idx_ff;
               end
            end
            // End of a pass: recharge once if the best counter is zero.
            if ((scan_cnt_ff == NUM_CNT) && !sample_ff) begin
               if (!recharge_ff && (best_ff == 11'sd0)) begin
                  recharge_in = 1'b1;
                  scan_cnt_in = '0;
                  best_in     = -11'sd1;
                  pick_in     = '0;
               end else begin
                  cur_in      = pick_ff;
                  switched_in = (pick_ff != cur_ff);
                  state_in    = ST_READ;
               end
            end
         end

         ST_READ: begin
            rd_addr  = cur_ff;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // Load the result register from the current slot.
            rsp_strobe_in = 1'b1;
            rsp_task_in   = 6'(cur_ff);
            rsp_sw_in     = switched_ff;
            rsp_rs_in     = resched_ff;
            rsp_rc_in     = recharge_ff;
            rsp_cnt_in    = rd_data.counter;
            rsp_pre_in    = rd_data.preempt;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_ff        <= '0;
         sample_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         sample_ff     <= sample_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Request, scan and result payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      slot_ff     <= slot_in;
      pres_ff     <= pres_in;
      run_ff      <= run_in;
      prio_ff     <= prio_in;
      cval_ff     <= cval_in;
      resched_ff  <= resched_in;
      recharge_ff <= recharge_in;
      switched_ff <= switched_in;
      scan_cnt_ff <= scan_cnt_in;
      rd_idx_ff   <= rd_addr;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      rsp_task_ff <= rsp_task_in;
      rsp_sw_ff   <= rsp_sw_in;
      rsp_rs_ff   <= rsp_rs_in;
      rsp_rc_ff   <= rsp_rc_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_pre_ff  <= rsp_pre_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_current_task    = rsp_task_ff;
   assign rsp_switched        = rsp_sw_ff;
   assign rsp_rescheduled     = rsp_rs_ff;
   assign rsp_recharged       = rsp_rc_ff;
   assign rsp_current_counter = rsp_cnt_ff;
   assign rsp_current_preempt = rsp_pre_ff;

   // A result follows only from the response state.
   a_strobe_from_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_RESP))
      else $error("result strobe without response state");

   // Switch and recharge are only reported with a selection pass.
   a_flags_need_resched: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_switched || rsp_recharged)) |-> rsp_rescheduled)
      else $error("switch or recharge reported without a selection pass");

   // The current slot index stays within the slot table.
   a_cur_in_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_ff) < NUM_TASKS))
      else $error("current slot index out of range");

   // An accepted transfer makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not start work");

endmodule : counter_priority_task_scheduler_top

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the counter/priority task scheduler top level.
`timescale 1ns / 100ps

module tb;
   import cpts_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int SLOTS        = NUM_TASKS_DEF;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
   localparam int RANDOM_ITEMS = 1400;
   localparam int MAX_REPORTS  = 10;
   localparam int MAX_GAP      = 40;
   localparam int DIRECTED_LEN = 27;

   // Op codes past the named ones; they leave the state alone.
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // One command as driven on the request ports.
   typedef struct packed {
      logic [2:0]         op;
      logic [5:0]         slot;
      logic               present;
      logic               runnable;
      logic [7:0]         prio;
      logic signed [10:0] count;
   } command_type;

   // One scheduler status as reported on the response ports.
   typedef struct packed {
      logic [5:0]         task_id;
      logic               switched;
      logic               rescheduled;
      logic               recharged;
      logic signed [10:0] counter;
      logic [3:0]         preempt;
   } status_type;

   // A directed row: the command and, where typed in, the status it must give.
   typedef struct packed {
      command_type cmd;
      logic        typed;
      status_type  want;
   } directed_row_type;

   localparam status_type UNCHECKED = '0;

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               start             = 1'b0;
   logic               busy;
   logic [2:0]         req_op            = '0;
   logic [5:0]         req_slot          = '0;
   logic               req_present       = 1'b0;
   logic               req_runnable      = 1'b0;
   logic [7:0]         req_priority_req  = '0;
   logic signed [10:0] req_counter_value = '0;
   logic               rsp_strobe;
   logic [5:0]         rsp_current_task;
   logic               rsp_switched;
   logic               rsp_rescheduled;
   logic               rsp_recharged;
   logic signed [10:0] rsp_current_counter;
   logic [3:0]         rsp_current_preempt;

   // Shadow copy of the task table and the current slot.
   logic tbl_present  [SLOTS];
   logic tbl_runnable [SLOTS];
   int   tbl_prio     [SLOTS];
   int   tbl_count    [SLOTS];
   int   tbl_preempt  [SLOTS];
   int   cur_slot;

   status_type       status_q [$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   int               idle_pct       = 0;
   logic             want_typed     = 1'b0;
   status_type       want_status    = '0;
   directed_row_type directed_rows [DIRECTED_LEN];

   counter_priority_task_scheduler_top uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_slot            (req_slot),
      .req_present         (req_present),
      .req_runnable        (req_runnable),
      .req_priority_req    (req_priority_req),
      .req_counter_value   (req_counter_value),
      .rsp_strobe          (rsp_strobe),
      .rsp_current_task    (rsp_current_task),
      .rsp_switched        (rsp_switched),
      .rsp_rescheduled     (rsp_rescheduled),
      .rsp_recharged       (rsp_recharged),
      .rsp_current_counter (rsp_current_counter),
      .rsp_current_preempt (rsp_current_preempt)
   );

   always #HALF_PERIOD clock = ~clock;

   // Clamp a time counter to the 11-bit signed range.
   function automatic int clamp_count(int v);
      if (v < CNT_MIN) return CNT_MIN;
      if (v > CNT_MAX) return CNT_MAX;
      return v;
   endfunction

   // Largest non-negative counter among runnable present slots, or -1.
   function automatic int best_candidate(output int pick);
      int best;
      best = -1;
      pick = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_present[i] && tbl_runnable[i] && tbl_count[i] > best) begin
            best = tbl_count[i];
            pick = i;
         end
      end
      return best;
   endfunction

   // Apply one command to the shadow table and work out the status it reports.
   function automatic status_type schedule_step(command_type c);
      status_type s;
      int         pick;
      s = '0;
      case (c.op)
         OP_TICK: begin
            tbl_count[cur_slot] = clamp_count(tbl_count[cur_slot] - 1);
            if (tbl_count[cur_slot] <= 0 && tbl_preempt[cur_slot] == 0) begin
               tbl_count[cur_slot] = 0;
               s.rescheduled = 1'b1;
            end
         end
         OP_YIELD: begin
            tbl_count[cur_slot] = 0;
            s.rescheduled = 1'b1;
         end
         OP_WRITE: begin
            tbl_present[c.slot]  = c.present;
            tbl_runnable[c.slot] = c.runnable;
            tbl_prio[c.slot]     = (c.prio == 8'd0) ? 1 : int'(c.prio);
            tbl_count[c.slot]    = $signed(c.count);
         end
         OP_RAISE: begin
            if (tbl_preempt[cur_slot] < PRE_MAX) tbl_preempt[cur_slot]++;
         end
         OP_LOWER: begin
            if (tbl_preempt[cur_slot] > 0) tbl_preempt[cur_slot]--;
         end
         default: ;
      endcase

      // Selection pass, with one recharge of every present slot when all are spent.
      if (s.rescheduled) begin
         if (best_candidate(pick) == 0) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_present[i])
                  tbl_count[i] = clamp_count((tbl_count[i] >>> 1) + tbl_prio[i]);
            end
            s.recharged = 1'b1;
            void'(best_candidate(pick));
         end
         s.switched = (pick != cur_slot);
         cur_slot   = pick;
      end

      s.task_id = 6'(cur_slot);
      s.counter = 11'(tbl_count[cur_slot]);
      s.preempt = 4'(tbl_preempt[cur_slot]);
      return s;
   endfunction

   // Random command fields; small counters and priorities dominate so that
   // the current task runs out often and recharges come around.
   function automatic command_type random_command(logic [2:0] op);
      command_type c;
      c.op       = op;
      c.slot     = 6'($urandom);
      c.present  = ($urandom_range(99) < 85);
      c.runnable = ($urandom_range(99) < 80);
      c.prio     = ($urandom_range(99) < 75) ? 8'($urandom_range(7)) : 8'($urandom);
      c.count    = ($urandom_range(99) < 80) ? 11'(int'($urandom_range(23)) - 3)
                                             : 11'($urandom);
      return c;
   endfunction

   function automatic logic [2:0] random_op();
      int r;
      r = $urandom_range(99);
      if (r < 40) return OP_TICK;
      if (r < 55) return OP_YIELD;
      if (r < 77) return OP_WRITE;
      if (r < 86) return OP_RAISE;
      if (r < 95) return OP_LOWER;
      return 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
   endfunction

   // Present one command after a random idle gap and hold it until the transfer.
   task automatic issue(command_type c, logic typed, status_type want);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start             <= 1'b1;
      req_op            <= c.op;
      req_slot          <= c.slot;
      req_present       <= c.present;
      req_runnable      <= c.runnable;
      req_priority_req  <= c.prio;
      req_counter_value <= c.count;
      want_typed        <= typed;
      want_status       <= want;
      do @(posedge clock); while (busy);
   endtask

   // Stop sending and wait until every expected status has come back.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (status_q.size() != 0) @(posedge clock);
   endtask

   // Check each reported status against the oldest expectation, then log new transfers.
   always @(posedge clock) begin
      status_type got;
      status_type expected;
      if (!reset) begin
         if (rsp_strobe) begin
            got = {rsp_current_task, rsp_switched, rsp_rescheduled, rsp_recharged,
                   rsp_current_counter, rsp_current_preempt};
            if (status_q.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("tb: unexpected status at cycle %0d: task %0d counter %0d",
                           cycle_count, got.task_id, $signed(got.counter));
               mismatch_count++;
            end else begin
               expected = status_q.pop_front();
               if (got !== expected) begin
                  if (mismatch_count < MAX_REPORTS) begin
                     $display("tb: mismatch at cycle %0d", cycle_count);
                     $display("tb:  expected task %0d sw %0b rs %0b rc %0b cnt %0d pre %0d",
                              expected.task_id, expected.switched,
                              expected.rescheduled, expected.recharged,
                              $signed(expected.counter), expected.preempt);
                     $display("tb:    actual task %0d sw %0b rs %0b rc %0b cnt %0d pre %0d",
                              got.task_id, got.switched, got.rescheduled, got.recharged,
                              $signed(got.counter), got.preempt);
                  end
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            expected = schedule_step({req_op, req_slot, req_present, req_runnable,
                                      req_priority_req, req_counter_value});
            if (want_typed) expected = want_status;
            status_q.push_back(expected);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      int sent;
      int burst;

      // Shadow table starts as the block does after reset.
      for (int i = 0; i < SLOTS; i++) begin
         tbl_present[i]  = (i == 0);
         tbl_runnable[i] = (i == 0);
         tbl_prio[i]     = 1;
         tbl_count[i]    = 0;
         tbl_preempt[i]  = 0;
      end
      cur_slot = 0;

      directed_rows = '{
         // After reset slot 0 runs with a zero counter, so the first tick recharges it.
         '{'{OP_TICK,  6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b1,
           '{6'd0,  1'b0, 1'b1, 1'b1, 11'sd1,  4'd0}},
         '{'{OP_RAISE, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b1,
           '{6'd0,  1'b0, 1'b0, 1'b0, 11'sd1,  4'd1}},
         // A held preemption count blocks the reschedule at zero and below.
         '{'{OP_TICK,  6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b1,
           '{6'd0,  1'b0, 1'b0, 1'b0, 11'sd0,  4'd1}},
         '{'{OP_TICK,  6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b1,
           '{6'd0,  1'b0, 1'b0, 1'b0, -11'sd1, 4'd1}},
         '{'{OP_LOWER, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b1,
           '{6'd0,  1'b0, 1'b0, 1'b0, -11'sd1, 4'd0}},
         // Lowering a zero count stays at zero.
         '{'{OP_LOWER, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b1,
           '{6'd0,  1'b0, 1'b0, 1'b0, -11'sd1, 4'd0}},
         '{'{OP_WRITE, 6'd63, 1'b1, 1'b1, 8'd255, CNT_MAX}, 1'b1,
           '{6'd0,  1'b0, 1'b0, 1'b0, -11'sd1, 4'd0}},
         // A zero priority is stored as one.
         '{'{OP_WRITE, 6'd1,  1'b1, 1'b0, 8'd0,   CNT_MIN}, 1'b1,
           '{6'd0,  1'b0, 1'b0, 1'b0, -11'sd1, 4'd0}},
         '{'{OP_YIELD, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b1,
           '{6'd63, 1'b1, 1'b1, 1'b0, CNT_MAX, 4'd0}},
         '{'{OP_RAISE, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         '{'{OP_TICK,  6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         '{'{OP_LOWER, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         // Run the current task down so that every candidate is spent.
         '{'{OP_WRITE, 6'd63, 1'b1, 1'b1, 8'd7,   11'sd1}, 1'b0, UNCHECKED},
         '{'{OP_TICK,  6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         // No candidate at all falls back to slot 0.
         '{'{OP_WRITE, 6'd63, 1'b0, 1'b1, 8'd7,   11'sd5}, 1'b0, UNCHECKED},
         '{'{OP_WRITE, 6'd0,  1'b1, 1'b0, 8'd1,   11'sd3}, 1'b0, UNCHECKED},
         '{'{OP_YIELD, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         // A negative counter never makes a task a candidate.
         '{'{OP_WRITE, 6'd5,  1'b1, 1'b1, 8'd9,   -11'sd5}, 1'b0, UNCHECKED},
         '{'{OP_YIELD, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         '{'{OP_SPARE_LO, 6'd63, 1'b1, 1'b1, 8'd255, -11'sd1}, 1'b0, UNCHECKED},
         // Equal counters go to the lower slot.
         '{'{OP_WRITE, 6'd10, 1'b1, 1'b1, 8'd3,   11'sd500}, 1'b0, UNCHECKED},
         '{'{OP_WRITE, 6'd11, 1'b1, 1'b1, 8'd3,   11'sd500}, 1'b0, UNCHECKED},
         '{'{OP_YIELD, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         '{'{OP_YIELD, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         // A tick at the bottom of the range saturates.
         '{'{OP_WRITE, 6'd11, 1'b1, 1'b1, 8'd3,   CNT_MIN}, 1'b0, UNCHECKED},
         '{'{OP_RAISE, 6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED},
         '{'{OP_TICK,  6'd0,  1'b0, 1'b0, 8'd0,   11'sd0}, 1'b0, UNCHECKED}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         issue(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
      wait_drained();

      // Random traffic in phases of sender idling, each drained before the next.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 0 : (phase == 1) ? 67 : 35;
         sent = 0;
         while (sent < RANDOM_ITEMS / 3) begin
            if ($urandom_range(99) < 3) begin
               // Preemption burst of 14 to 18 raises, which can reach saturation, ticks while held, then release.
               burst = $urandom_range(18, 14);
               repeat (burst) issue(random_command(OP_RAISE), 1'b0, UNCHECKED);
               repeat (3) issue(random_command(OP_TICK), 1'b0, UNCHECKED);
               repeat (burst + 1) issue(random_command(OP_LOWER), 1'b0, UNCHECKED);
               sent += 2 * burst + 4;
            end else begin
               issue(random_command(random_op()), 1'b0, UNCHECKED);
               sent++;
            end
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && status_q.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

### sim.f
rtl/cpts_pkg.sv
rtl/cpts_slot_mem.sv
rtl/counter_priority_task_scheduler_top.sv
dv/tb.sv
